// ===== sv/copy_text_row_escaper_top_assert.svh =====
// ----------------------------------------------------------------------------
// copy_text_row_escaper_top_assert.svh
// Assertion macros used by the escaper checker. They expect signals named
// clk and rst_n in the scope of use.
// ----------------------------------------------------------------------------
`ifndef COPY_TEXT_ROW_ESCAPER_TOP_ASSERT_SVH
`define COPY_TEXT_ROW_ESCAPER_TOP_ASSERT_SVH

// Same-cycle implication, held off during reset
`define CTE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset
`define CTE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/cte_pkg.sv =====
// ----------------------------------------------------------------------------
// cte_pkg
// Shared types, codes and byte constants of the COPY text row escaper.
// ----------------------------------------------------------------------------
package cte_pkg;

    // Longest byte run one item can produce (backslash N CR LF)
    localparam int MAX_RUN     = 4;
    localparam int RUN_IDX_W   = 2;
    localparam int QUEUE_DEPTH = 4;

    // Item opcodes
    typedef enum logic [1:0] {
        OP_DATA    = 2'd0,
        OP_COL_END = 2'd1,
        OP_NULL    = 2'd2,
        OP_ROW_END = 2'd3
    } opcode_t;

    // Configuration register indexes
    typedef enum logic {
        CFG_DELIMITER = 1'b0,
        CFG_CRLF_MODE = 1'b1
    } cfg_index_t;

    localparam logic [7:0] BSLASH        = 8'h5C;
    localparam logic [7:0] NULL_LETTER   = 8'h4E;
    localparam logic [7:0] CHAR_CR       = 8'h0D;
    localparam logic [7:0] CHAR_LF       = 8'h0A;
    localparam logic [7:0] DELIM_RESET   = 8'h09;
    localparam logic [7:0] NO_LETTER     = 8'h00;

    // One classified item: the bytes to send and the index of the final one
    typedef struct packed {
        logic [MAX_RUN-1:0][7:0]  run_bytes;
        logic [RUN_IDX_W-1:0]     last_idx;
    } run_t;

    // Letter for the lettered control codes, NO_LETTER for all else
    function automatic logic [7:0] escape_letter(input logic [7:0] c);
        logic [7:0] letter;
        case (c)
            8'h08:   letter = 8'h62; // b
            8'h0C:   letter = 8'h66; // f
            8'h0A:   letter = 8'h6E; // n
            8'h0D:   letter = 8'h72; // r
            8'h09:   letter = 8'h74; // t
            8'h0B:   letter = 8'h76; // v
            default: letter = NO_LETTER;
        endcase
        return letter;
    endfunction

endpackage

// ===== sv/cte_front.sv =====
// ----------------------------------------------------------------------------
// cte_front
// Holds the configuration and classifies each item into its escaped byte run.
// ----------------------------------------------------------------------------
module cte_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [7:0]          cfg_data,
    input  logic [1:0]          opcode,
    input  logic [7:0]          data_byte,
    input  logic                last_column,
    output cte_pkg::run_t       run
);

    logic [7:0]                     delimiter_reg;
    logic                           crlf_mode_reg;
    cte_pkg::opcode_t               op;
    logic [7:0]                     letter;
    logic [cte_pkg::RUN_IDX_W-1:0]  base;

    // Update configuration registers on a write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delimiter_reg <= cte_pkg::DELIM_RESET;
            crlf_mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cte_pkg::cfg_index_t'(cfg_index))
                cte_pkg::CFG_DELIMITER: delimiter_reg <= cfg_data;
                cte_pkg::CFG_CRLF_MODE: crlf_mode_reg <= cfg_data[0];
                default:                delimiter_reg <= delimiter_reg;
            endcase
        end
    end

    assign op     = cte_pkg::opcode_t'(opcode);
    assign letter = cte_pkg::escape_letter(data_byte);

    // Build the byte run of the item
    always_comb
    begin
        run  = '0;
        base = '0;
        case (op)
            cte_pkg::OP_DATA:
            begin
                if (letter != cte_pkg::NO_LETTER)
                begin
                    run.run_bytes[0] = cte_pkg::BSLASH;
                    run.run_bytes[1] = letter;
                    run.last_idx     = 2'd1;
                end
                else if (data_byte == cte_pkg::BSLASH || data_byte == delimiter_reg)
                begin
                    run.run_bytes[0] = cte_pkg::BSLASH;
                    run.run_bytes[1] = data_byte;
                    run.last_idx     = 2'd1;
                end
                else
                begin
                    run.run_bytes[0] = data_byte;
                    run.last_idx     = 2'd0;
                end
            end
            cte_pkg::OP_ROW_END:
            begin
                if (crlf_mode_reg)
                begin
                    run.run_bytes[0] = cte_pkg::CHAR_CR;
                    run.run_bytes[1] = cte_pkg::CHAR_LF;
                    run.last_idx     = 2'd1;
                end
                else
                begin
                    run.run_bytes[0] = cte_pkg::CHAR_LF;
                    run.last_idx     = 2'd0;
                end
            end
            cte_pkg::OP_COL_END, cte_pkg::OP_NULL:
            begin
                // Null marker goes ahead of the column terminator
                if (op == cte_pkg::OP_NULL)
                begin
                    run.run_bytes[0] = cte_pkg::BSLASH;
                    run.run_bytes[1] = cte_pkg::NULL_LETTER;
                    base             = 2'd2;
                end
                if (last_column && crlf_mode_reg)
                begin
                    run.run_bytes[base]         = cte_pkg::CHAR_CR;
                    run.run_bytes[2'(base + 1)] = cte_pkg::CHAR_LF;
                    run.last_idx                = 2'(base + 1);
                end
                else if (last_column)
                begin
                    run.run_bytes[base] = cte_pkg::CHAR_LF;
                    run.last_idx        = base;
                end
                else
                begin
                    run.run_bytes[base] = delimiter_reg;
                    run.last_idx        = base;
                end
            end
            default:
            begin
                run = '0;
            end
        endcase
    end

endmodule

// ===== sv/cte_queue.sv =====
// ----------------------------------------------------------------------------
// cte_queue
// Short queue of classified byte runs between the front and the back.
// ----------------------------------------------------------------------------
module cte_queue #(
    parameter int DEPTH = cte_pkg::QUEUE_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  cte_pkg::run_t   wr_run,
    output logic            full,
    input  logic            rd_en,
    output cte_pkg::run_t   rd_run,
    output logic            empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cte_pkg::run_t      mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    assign full   = (cnt_reg == CNT_W'(DEPTH));
    assign empty  = (cnt_reg == '0);
    assign rd_run = mem_reg[rd_ptr_reg];

    // Advance pointers with wrap and track fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store the run on a write
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_run;
        end
    end

endmodule

// ===== sv/cte_back.sv =====
// ----------------------------------------------------------------------------
// cte_back
// Steps through the oldest queued run, one byte per output transfer.
// ----------------------------------------------------------------------------
module cte_back (
    input  logic            clk,
    input  logic            rst_n,
    input  cte_pkg::run_t   head_run,
    input  logic            head_empty,
    output logic            head_drop,
    output logic            empty,
    input  logic            pop,
    output logic [7:0]      out_byte,
    output logic            run_last
);

    logic [cte_pkg::RUN_IDX_W-1:0]  idx_reg, idx_next;
    logic                           xfer;

    assign empty     = head_empty;
    assign out_byte  = head_run.run_bytes[idx_reg];
    assign run_last  = (idx_reg == head_run.last_idx);
    assign xfer      = pop && !head_empty;
    assign head_drop = xfer && run_last;

    // Advance within the run, restart on its final byte
    always_comb
    begin
        idx_next = idx_reg;
        if (xfer)
        begin
            idx_next = run_last ? '0 : idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

endmodule

// ===== sv/copy_text_row_escaper_top.sv =====
// ----------------------------------------------------------------------------
// copy_text_row_escaper_top
// Serializes column bytes and column events into COPY text format bytes.
// ----------------------------------------------------------------------------
// Each accepted item is classified in the cycle it is pushed and turns into a
// run of one to four output bytes held in a QUEUE_DEPTH-entry queue; the
// output side sends one byte per pop, so the first byte of an item pushed
// into an empty queue is visible the cycle after its push. Items are taken
// one per cycle while the queue has room, and the sustained rate is one
// output byte per cycle while pop is held: a plain data byte gives one byte,
// an escape two, a null column at a CRLF row end four. The consumer's pop
// sets that rate. Configuration writes take effect at the next edge and are
// to be made only while the block holds no pending bytes.
// ----------------------------------------------------------------------------
module copy_text_row_escaper_top #(
    parameter int QUEUE_DEPTH = cte_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  opcode,
    input  logic [7:0]  data_byte,
    input  logic        last_column,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  out_byte,
    output logic        run_last
);

    cte_pkg::run_t  new_run;
    cte_pkg::run_t  head_run;
    logic           head_empty;
    logic           head_drop;
    logic           wr_en;

    assign wr_en = push && !full;

    // Classify items
    cte_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .opcode      (opcode),
        .data_byte   (data_byte),
        .last_column (last_column),
        .run         (new_run)
    );

    // Decouple front and back
    cte_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (wr_en),
        .wr_run (new_run),
        .full   (full),
        .rd_en  (head_drop),
        .rd_run (head_run),
        .empty  (head_empty)
    );

    // Send bytes
    cte_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_run   (head_run),
        .head_empty (head_empty),
        .head_drop  (head_drop),
        .empty      (empty),
        .pop        (pop),
        .out_byte   (out_byte),
        .run_last   (run_last)
    );

endmodule

// ===== sv/cte_checker.sv =====
// ----------------------------------------------------------------------------
// cte_checker
// Port-level checks on the escaper's queue interfaces, bound to the top.
// ----------------------------------------------------------------------------
`include "copy_text_row_escaper_top_assert.svh"

module cte_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        full,
    input  logic        empty,
    input  logic        pop,
    input  logic [7:0]  out_byte,
    input  logic        run_last
);

    logic       take;
    logic       stall;
    logic [8:0] head_word;
    logic       lead_ok;

    // Name the output transfer, the output stall and the waiting byte
    assign take      = pop && !empty;
    assign stall     = !empty && !pop;
    assign head_word = {out_byte, run_last};

    // Bytes that may lead into more bytes of the same run
    assign lead_ok   = (out_byte == cte_pkg::BSLASH)
                       || (out_byte == cte_pkg::NULL_LETTER)
                       || (out_byte == cte_pkg::CHAR_CR);

    // Hold a waiting byte until it is taken
    `CTE_ASSERT_NEXT(a_out_hold, stall, !empty && $stable(head_word), "held byte changed")

    // Keep a run going without gaps
    `CTE_ASSERT_NEXT(a_run_no_gap, take && !run_last, !empty, "run broken by empty")

    // Free a slot once a run completes
    `CTE_ASSERT_NEXT(a_run_frees, take && run_last, !full, "full after run completed")

    // Only backslash, N or CR lead into more bytes of a run
    `CTE_ASSERT_NOW(a_run_lead, !empty && !run_last, lead_ok, "unexpected byte inside run")

endmodule

bind copy_text_row_escaper_top cte_checker u_cte_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .out_byte (out_byte),
    .run_last (run_last)
);
